[rtl/cil_pkg.sv]
// Shared definitions for the coupled index lookup block: field widths, codes,
// the control word layout and the microcode table of the sequencer.
// No dependencies.
`default_nettype none

package cil_pkg;

   localparam int DEF_MAX_SENDERS   = 16;
   localparam int DEF_MAX_RECEIVERS = 16;
   localparam int DEF_COUNT_BITS    = 16;

   localparam int RANK_BITS   = 4;
   localparam int CSR_BITS    = 5;
   localparam int INDEX_BITS  = 20;
   localparam int WCOUNT_BITS = 16;
   localparam int STATUS_BITS = 2;

   localparam logic [INDEX_BITS-1:0] OFFSET_MAX = '1;
   localparam logic [CSR_BITS-1:0]   CSR_RESET  = 5'd16;

   localparam logic OP_WRITE      = 1'b0;
   localparam logic OP_QUERY      = 1'b1;
   localparam logic ROLE_SENDER   = 1'b0;
   localparam logic ROLE_RECEIVER = 1'b1;
   localparam logic CSR_SENDERS   = 1'b0;
   localparam logic CSR_RECEIVERS = 1'b1;

   localparam logic [STATUS_BITS-1:0] ST_WRITE_DONE = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_FOUND      = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND  = 2'd2;

   // microprogram addresses
   typedef logic [3:0] step_type;
   localparam step_type P_CLEAR    = 4'd0;
   localparam step_type P_IDLE     = 4'd1;
   localparam step_type P_DISPATCH = 4'd2;
   localparam step_type P_WRITE    = 4'd3;
   localparam step_type P_QCHECK   = 4'd4;
   localparam step_type P_SREAD    = 4'd5;
   localparam step_type P_SEVAL    = 4'd6;
   localparam step_type P_OINIT    = 4'd7;
   localparam step_type P_OREAD    = 4'd8;
   localparam step_type P_OEVAL    = 4'd9;
   localparam step_type P_EMIT     = 4'd10;

   typedef enum logic [3:0] {
      ACT_NONE   = 4'd0,
      ACT_CLEAR  = 4'd1,
      ACT_ACCEPT = 4'd2,
      ACT_WRITE  = 4'd3,
      ACT_QINIT  = 4'd4,
      ACT_SEVAL  = 4'd5,
      ACT_OINIT  = 4'd6,
      ACT_OEVAL  = 4'd7,
      ACT_EMIT   = 4'd8
   } act_type;

   typedef enum logic [0:0] {
      RD_SEARCH = 1'b0,
      RD_OFFSET = 1'b1
   } rd_src_type;

   typedef enum logic [3:0] {
      J_ALWAYS     = 4'd0,
      J_ACCEPT     = 4'd1,
      J_QUERY      = 4'd2,
      J_CLEAR_DONE = 4'd3,
      J_RANK_BAD   = 4'd4,
      J_SEARCH_END = 4'd5,
      J_MISS       = 4'd6,
      J_OFFSET_END = 4'd7,
      J_OUT_FREE   = 4'd8
   } cond_type;

   typedef struct packed {
      act_type    act;
      rd_src_type rd_src;
      cond_type   cond;
      step_type   on_true;
      step_type   on_false;
   } uword_type;

   function automatic uword_type ucode(step_type step);
      uword_type w;
      w = '{ACT_NONE, RD_SEARCH, J_ALWAYS, P_IDLE, P_IDLE};
      unique case (step)
         P_CLEAR:    w = '{ACT_CLEAR,  RD_SEARCH, J_CLEAR_DONE, P_IDLE,     P_CLEAR};
         P_IDLE:     w = '{ACT_ACCEPT, RD_SEARCH, J_ACCEPT,     P_DISPATCH, P_IDLE};
         P_DISPATCH: w = '{ACT_NONE,   RD_SEARCH, J_QUERY,      P_QCHECK,   P_WRITE};
         P_WRITE:    w = '{ACT_WRITE,  RD_SEARCH, J_ALWAYS,     P_EMIT,     P_EMIT};
         P_QCHECK:   w = '{ACT_QINIT,  RD_SEARCH, J_RANK_BAD,   P_EMIT,     P_SREAD};
         P_SREAD:    w = '{ACT_NONE,   RD_SEARCH, J_SEARCH_END, P_EMIT,     P_SEVAL};
         P_SEVAL:    w = '{ACT_SEVAL,  RD_SEARCH, J_MISS,       P_SREAD,    P_OINIT};
         P_OINIT:    w = '{ACT_OINIT,  RD_OFFSET, J_ALWAYS,     P_OREAD,    P_OREAD};
         P_OREAD:    w = '{ACT_NONE,   RD_OFFSET, J_OFFSET_END, P_EMIT,     P_OEVAL};
         P_OEVAL:    w = '{ACT_OEVAL,  RD_OFFSET, J_ALWAYS,     P_OREAD,    P_OREAD};
         P_EMIT:     w = '{ACT_EMIT,   RD_SEARCH, J_OUT_FREE,   P_IDLE,     P_EMIT};
         default:    w = '{ACT_NONE,   RD_SEARCH, J_ALWAYS,     P_IDLE,     P_IDLE};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

[rtl/cil_if.sv]
// Valid/ready channels of the coupled index lookup block: request and response.
// Depends on nothing; field widths are fixed by the item layout.
`default_nettype none

interface cil_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [3:0]  write_row;
   logic [3:0]  write_column;
   logic [15:0] write_count;
   logic        query_role;
   logic [3:0]  query_rank;
   logic [19:0] unit_index;

   modport source (output valid, opcode, write_row, write_column, write_count,
                   query_role, query_rank, unit_index, input ready);
   modport sink   (input valid, opcode, write_row, write_column, write_count,
                   query_role, query_rank, unit_index, output ready);
endinterface

interface cil_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  partner_rank;
   logic [19:0] partner_offset;

   modport source (output valid, status, partner_rank, partner_offset, input ready);
   modport sink   (input valid, status, partner_rank, partner_offset, output ready);
endinterface

`default_nettype wire

[rtl/coupled_index_lookup.sv]
// Coupled index lookup: count table, microcoded control and datapath.
// Depends on cil_pkg and the channel interfaces in cil_if.sv.
//
// After reset the block sweeps all MAX_SENDERS*MAX_RECEIVERS entries of the
// count table to zero (256 at the defaults), one entry per cycle. No request is
// taken until the sweep ends, but CSR writes are. Every table access goes
// through one memory with a write port and a registered read port. The sequencer
// spends a read step and an evaluate step on each entry that a query reads. A
// write passes the accept, dispatch, write and emit steps. A query that finds
// partner p for local rank r reads p+1 entries in its search and r entries for
// its offset; a query that misses reads every entry of its search row or column,
// and one with a local rank outside the ranks in use goes from its check step
// straight to emit. A result waits in the emit step while the output register is
// full and rsp_chan.ready is low. One item is in flight at a time; the next
// request is taken as soon as the result sits in the output register.
`default_nettype none

module coupled_index_lookup #(
   parameter int MAX_SENDERS   = cil_pkg::DEF_MAX_SENDERS,
   parameter int MAX_RECEIVERS = cil_pkg::DEF_MAX_RECEIVERS,
   parameter int COUNT_BITS    = cil_pkg::DEF_COUNT_BITS
) (
   input  wire                           clock,
   input  wire                           reset,
   cil_req_if.sink                       req_chan,
   cil_rsp_if.source                     rsp_chan,
   input  wire                           csr_write,
   input  wire                           csr_index,
   input  wire  [cil_pkg::CSR_BITS-1:0]  csr_data
);
   import cil_pkg::*;

   localparam int CELLS     = MAX_SENDERS * MAX_RECEIVERS;
   localparam int ADDR_BITS = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int SUM_BITS  = ((COUNT_BITS > INDEX_BITS) ? COUNT_BITS : INDEX_BITS) + 1;

   // sequencer
   step_type  step_ff, step_in;
   uword_type uw;
   logic      cond_hit;

   // configuration
   logic [CSR_BITS-1:0] senders_ff, senders_in;
   logic [CSR_BITS-1:0] receivers_ff, receivers_in;
   logic [CSR_BITS-1:0] ns, nr, lim, own;

   // latched request
   logic                  op_ff, op_in;
   logic [RANK_BITS-1:0]  row_ff, row_in;
   logic [RANK_BITS-1:0]  col_ff, col_in;
   logic [COUNT_BITS-1:0] cnt_ff, cnt_in;
   logic                  role_ff, role_in;
   logic [RANK_BITS-1:0]  rank_ff, rank_in;
   logic [INDEX_BITS-1:0] idx_ff, idx_in;

   // datapath
   logic [ADDR_BITS-1:0]   clr_ff, clr_in;
   logic [CSR_BITS-1:0]    loop_ff, loop_in;
   logic [CSR_BITS-1:0]    partner_ff, partner_in;
   logic [INDEX_BITS-1:0]  sum_ff, sum_in;
   logic [INDEX_BITS-1:0]  off_ff, off_in;
   logic [STATUS_BITS-1:0] res_status_ff, res_status_in;

   // output register
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [STATUS_BITS-1:0] rsp_status_ff, rsp_status_in;
   logic [RANK_BITS-1:0]   rsp_rank_ff, rsp_rank_in;
   logic [INDEX_BITS-1:0]  rsp_offset_ff, rsp_offset_in;

   // count table
   logic [COUNT_BITS-1:0] table_mem [CELLS];
   logic [COUNT_BITS-1:0] rd_data_ff;
   logic [ADDR_BITS-1:0]  rd_addr, wr_addr;
   logic [COUNT_BITS-1:0] wr_data;
   logic                  wr_en;
   logic [CSR_BITS-1:0]   rd_row, rd_col;

   logic                recv, rank_bad, wr_in_range, out_free, hit;
   logic [SUM_BITS-1:0] sum_next, off_next;

   always_comb begin
      if (senders_ff == '0) begin
         ns = CSR_BITS'(1);
      end else if (32'(senders_ff) > MAX_SENDERS) begin
         ns = CSR_BITS'(MAX_SENDERS);
      end else begin
         ns = senders_ff;
      end
      if (receivers_ff == '0) begin
         nr = CSR_BITS'(1);
      end else if (32'(receivers_ff) > MAX_RECEIVERS) begin
         nr = CSR_BITS'(MAX_RECEIVERS);
      end else begin
         nr = receivers_ff;
      end
   end

   assign recv        = (role_ff == ROLE_RECEIVER);
   assign lim         = recv ? ns : nr;
   assign own         = recv ? nr : ns;
   assign rank_bad    = (CSR_BITS'(rank_ff) >= own);
   assign wr_in_range = (CSR_BITS'(row_ff) < ns) && (CSR_BITS'(col_ff) < nr);
   assign out_free    = !rsp_valid_ff || rsp_chan.ready;

   assign sum_next = SUM_BITS'(sum_ff) + SUM_BITS'(rd_data_ff);
   assign off_next = SUM_BITS'(off_ff) + SUM_BITS'(rd_data_ff);
   assign hit      = (sum_next >= SUM_BITS'(idx_ff));

   // table address of the entry the current step reads
   always_comb begin
      if (uw.rd_src == RD_SEARCH) begin
         rd_row = recv ? loop_ff : CSR_BITS'(rank_ff);
         rd_col = recv ? CSR_BITS'(rank_ff) : loop_ff;
      end else begin
         rd_row = recv ? partner_ff : loop_ff;
         rd_col = recv ? loop_ff : partner_ff;
      end
   end
   assign rd_addr = ADDR_BITS'(32'(rd_row) * MAX_RECEIVERS + 32'(rd_col));

   assign uw = ucode(step_ff);

   always_comb begin
      unique case (uw.cond)
         J_ALWAYS:     cond_hit = 1'b1;
         J_ACCEPT:     cond_hit = req_chan.valid;
         J_QUERY:      cond_hit = (op_ff == OP_QUERY);
         J_CLEAR_DONE: cond_hit = (clr_ff == ADDR_BITS'(CELLS - 1));
         J_RANK_BAD:   cond_hit = rank_bad;
         J_SEARCH_END: cond_hit = (loop_ff >= lim);
         J_MISS:       cond_hit = !hit;
         J_OFFSET_END: cond_hit = (loop_ff >= CSR_BITS'(rank_ff));
         J_OUT_FREE:   cond_hit = out_free;
         default:      cond_hit = 1'b1;
      endcase
      step_in = cond_hit ? uw.on_true : uw.on_false;
   end

   assign req_chan.ready = (uw.act == ACT_ACCEPT);

   always_comb begin
      senders_in    = senders_ff;
      receivers_in  = receivers_ff;
      op_in         = op_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cnt_in        = cnt_ff;
      role_in       = role_ff;
      rank_in       = rank_ff;
      idx_in        = idx_ff;
      clr_in        = clr_ff;
      loop_in       = loop_ff;
      partner_in    = partner_ff;
      sum_in        = sum_ff;
      off_in        = off_ff;
      res_status_in = res_status_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      wr_en         = 1'b0;
      wr_addr       = ADDR_BITS'(32'(row_ff) * MAX_RECEIVERS + 32'(col_ff));
      wr_data       = cnt_ff;

      if (csr_write) begin
         unique case (csr_index)
            CSR_SENDERS:   senders_in   = csr_data;
            CSR_RECEIVERS: receivers_in = csr_data;
            default:       senders_in   = senders_ff;
         endcase
      end

      unique case (uw.act)
         ACT_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = '0;
            clr_in  = clr_ff + ADDR_BITS'(1);
         end
         ACT_ACCEPT: begin
            if (req_chan.valid) begin
               op_in   = req_chan.opcode;
               row_in  = req_chan.write_row;
               col_in  = req_chan.write_column;
               cnt_in  = COUNT_BITS'(req_chan.write_count);
               role_in = req_chan.query_role;
               rank_in = req_chan.query_rank;
               idx_in  = req_chan.unit_index;
            end
         end
         ACT_WRITE: begin
            wr_en         = wr_in_range;
            res_status_in = ST_WRITE_DONE;
         end
         ACT_QINIT: begin
            loop_in       = '0;
            sum_in        = '0;
            res_status_in = ST_NOT_FOUND;
         end
         ACT_SEVAL: begin
            if (hit) begin
               partner_in = loop_ff;
               off_in     = idx_ff - sum_ff;
            end else begin
               // no hit means the sum stays below the index
               sum_in  = sum_next[INDEX_BITS-1:0];
               loop_in = loop_ff + CSR_BITS'(1);
            end
         end
         ACT_OINIT: begin
            loop_in       = '0;
            res_status_in = ST_FOUND;
         end
         ACT_OEVAL: begin
            if (off_next > SUM_BITS'(OFFSET_MAX)) begin
               off_in = OFFSET_MAX;
            end else begin
               off_in = off_next[INDEX_BITS-1:0];
            end
            loop_in = loop_ff + CSR_BITS'(1);
         end
         ACT_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               if (res_status_ff == ST_FOUND) begin
                  rsp_rank_in   = partner_ff[RANK_BITS-1:0];
                  rsp_offset_in = off_ff;
               end else begin
                  rsp_rank_in   = '0;
                  rsp_offset_in = '0;
               end
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= P_CLEAR;
         clr_ff       <= '0;
         senders_ff   <= CSR_RESET;
         receivers_ff <= CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         clr_ff       <= clr_in;
         senders_ff   <= senders_in;
         receivers_ff <= receivers_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      cnt_ff        <= cnt_in;
      role_ff       <= role_in;
      rank_ff       <= rank_in;
      idx_ff        <= idx_in;
      loop_ff       <= loop_in;
      partner_ff    <= partner_in;
      sum_ff        <= sum_in;
      off_ff        <= off_in;
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_offset_ff <= rsp_offset_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.status         = rsp_status_ff;
   assign rsp_chan.partner_rank   = rsp_rank_ff;
   assign rsp_chan.partner_offset = rsp_offset_ff;

endmodule

`default_nettype wire

[test/coupled_index_lookup_tb.sv]
// Self-checking testbench for coupled_index_lookup: random and directed writes and
// queries against an in-bench count table predictor, with random stalls on both sides.
// Depends on cil_pkg, the channel interfaces in cil_if.sv and the block itself.
`default_nettype none

module coupled_index_lookup_tb;
   import cil_pkg::*;

   localparam int NUM_ROWS    = DEF_MAX_SENDERS;
   localparam int NUM_COLS    = DEF_MAX_RECEIVERS;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 100;

   typedef struct packed {
      logic                   opcode;
      logic [RANK_BITS-1:0]   write_row;
      logic [RANK_BITS-1:0]   write_column;
      logic [WCOUNT_BITS-1:0] write_count;
      logic                   query_role;
      logic [RANK_BITS-1:0]   query_rank;
      logic [INDEX_BITS-1:0]  unit_index;
   } lookup_item_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [RANK_BITS-1:0]   partner_rank;
      logic [INDEX_BITS-1:0]  partner_offset;
   } lookup_result_type;

   logic                clock;
   logic                reset;
   logic                csr_write;
   logic                csr_index;
   logic [CSR_BITS-1:0] csr_data;

   cil_req_if req_chan ();
   cil_rsp_if rsp_chan ();

   coupled_index_lookup u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   // predictor state
   logic [WCOUNT_BITS-1:0] count_model [NUM_ROWS][NUM_COLS];
   logic [CSR_BITS-1:0]    senders_cfg;
   logic [CSR_BITS-1:0]    receivers_cfg;

   lookup_item_type   request_queue [$];
   lookup_result_type predicted_results [$];
   lookup_item_type   offered;
   bit                offer_live;
   bit                steady;
   int unsigned       mismatch_count;
   int unsigned       quiet_cycles;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   function automatic int unsigned ranks_in_use(logic [CSR_BITS-1:0] value, int unsigned limit);
      if (value == '0) return 1;
      return (value > limit) ? limit : value;
   endfunction

   function automatic lookup_result_type predict_lookup(lookup_item_type it);
      lookup_result_type res;
      int unsigned       ns, nr, span, sum, rem, offset, entry, partner;
      bit                recv, found;
      res = '0;
      ns  = ranks_in_use(senders_cfg, NUM_ROWS);
      nr  = ranks_in_use(receivers_cfg, NUM_COLS);
      if (it.opcode == OP_WRITE) begin
         if (it.write_row < ns && it.write_column < nr)
            count_model[it.write_row][it.write_column] = it.write_count;
         res.status = ST_WRITE_DONE;
         return res;
      end
      recv = (it.query_role == ROLE_RECEIVER);
      if (it.query_rank >= (recv ? nr : ns)) begin
         res.status = ST_NOT_FOUND;
         return res;
      end
      span    = recv ? ns : nr;
      sum     = 0;
      rem     = 0;
      partner = 0;
      found   = 1'b0;
      for (int i = 0; i < span && !found; i++) begin
         entry = recv ? count_model[i][it.query_rank] : count_model[it.query_rank][i];
         if (sum + entry >= it.unit_index) begin
            rem     = it.unit_index - sum;
            partner = i;
            found   = 1'b1;
         end else begin
            sum += entry;
         end
      end
      if (!found) begin
         res.status = ST_NOT_FOUND;
         return res;
      end
      // add what the partner exchanges with the local ranks below this one
      offset = rem;
      for (int i = 0; i < it.query_rank; i++)
         offset += recv ? count_model[partner][i] : count_model[i][partner];
      if (offset > OFFSET_MAX) offset = OFFSET_MAX;
      res.status         = ST_FOUND;
      res.partner_rank   = RANK_BITS'(partner);
      res.partner_offset = INDEX_BITS'(offset);
      return res;
   endfunction

   function automatic lookup_item_type noise_item();
      logic [63:0] junk;
      junk = {$urandom, $urandom};
      return junk[$bits(lookup_item_type)-1:0];
   endfunction

   task automatic push_write(int unsigned row, int unsigned col, int unsigned count);
      lookup_item_type it;
      it              = noise_item();
      it.opcode       = OP_WRITE;
      it.write_row    = RANK_BITS'(row);
      it.write_column = RANK_BITS'(col);
      it.write_count  = WCOUNT_BITS'(count);
      request_queue.push_back(it);
   endtask

   task automatic push_query(logic role, int unsigned rank, int unsigned index);
      lookup_item_type it;
      it            = noise_item();
      it.opcode     = OP_QUERY;
      it.query_role = role;
      it.query_rank = RANK_BITS'(rank);
      it.unit_index = INDEX_BITS'(index);
      request_queue.push_back(it);
   endtask

   // fill part of the in-use table first, then mix writes with queries aimed at the sums
   task automatic queue_phase(int n_items, int unsigned count_max);
      int unsigned ns, nr, own, span, index_max, pick;
      logic        role;
      ns = ranks_in_use(senders_cfg, NUM_ROWS);
      nr = ranks_in_use(receivers_cfg, NUM_COLS);
      for (int k = 0; k < n_items; k++) begin
         pick = $urandom_range(99);
         if (k < 32 || pick < 45) begin
            pick = $urandom_range(19);
            push_write(($urandom_range(99) < 85) ? $urandom_range(ns - 1) : $urandom_range(15),
                       ($urandom_range(99) < 85) ? $urandom_range(nr - 1) : $urandom_range(15),
                       (pick == 0) ? 0 :
                       (pick == 1) ? 16'hFFFF : $urandom_range(count_max));
         end else begin
            role      = 1'($urandom_range(1));
            own       = (role == ROLE_RECEIVER) ? nr : ns;
            span      = (role == ROLE_RECEIVER) ? ns : nr;
            index_max = (count_max + 1) * span / 2;
            if (index_max > OFFSET_MAX) index_max = OFFSET_MAX;
            pick = $urandom_range(19);
            push_query(role,
                       ($urandom_range(99) < 90) ? $urandom_range(own - 1) : $urandom_range(15),
                       (pick == 0) ? 0 :
                       (pick < 3) ? $urandom_range(OFFSET_MAX) : $urandom_range(index_max));
         end
      end
   endtask

   task automatic wait_drained();
      while (request_queue.size() != 0 || offer_live || predicted_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic set_ranks(logic [CSR_BITS-1:0] senders, logic [CSR_BITS-1:0] receivers);
      @(posedge clock);
      csr_write   <= 1'b1;
      csr_index   <= CSR_SENDERS;
      csr_data    <= senders;
      senders_cfg  = senders;
      @(posedge clock);
      csr_index     <= CSR_RECEIVERS;
      csr_data      <= receivers;
      receivers_cfg  = receivers;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic void compare_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // request driver: hold valid until the transfer, then idle or advance
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         offer_live = 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            predicted_results.push_back(predict_lookup(offered));
            offer_live = 1'b0;
         end
         if (!offer_live) begin
            if (request_queue.size() != 0 && (steady || $urandom_range(99) >= 14)) begin
               offered    = request_queue.pop_front();
               offer_live = 1'b1;
               req_chan.opcode       <= offered.opcode;
               req_chan.write_row    <= offered.write_row;
               req_chan.write_column <= offered.write_column;
               req_chan.write_count  <= offered.write_count;
               req_chan.query_role   <= offered.query_role;
               req_chan.query_rank   <= offered.query_rank;
               req_chan.unit_index   <= offered.unit_index;
               req_chan.valid        <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      lookup_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (predicted_results.size() == 0) begin
               $error("result transfer with nothing predicted: status %0d", rsp_chan.status);
               mismatch_count++;
            end else begin
               want = predicted_results.pop_front();
               compare_field("status", want.status, rsp_chan.status);
               compare_field("partner_rank", want.partner_rank, rsp_chan.partner_rank);
               compare_field("partner_offset", want.partner_offset, rsp_chan.partner_offset);
            end
         end
         rsp_chan.ready <= steady || ($urandom_range(99) >= 14);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("coupled_index_lookup regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [CSR_BITS-1:0] plan_senders   [8] = '{16, 1, 0, 31, 16, 1, 5, 0};
      logic [CSR_BITS-1:0] plan_receivers [8] = '{16, 1, 0, 31, 1, 16, 11, 0};
      int unsigned         plan_counts    [8] = '{65535, 4095, 15, 65535, 255, 255, 4095, 65535};
      reset          = 1'b1;
      csr_write      = 1'b0;
      csr_index      = CSR_SENDERS;
      csr_data       = '0;
      req_chan.valid = 1'b0;
      req_chan.opcode       = OP_WRITE;
      req_chan.write_row    = '0;
      req_chan.write_column = '0;
      req_chan.write_count  = '0;
      req_chan.query_role   = ROLE_SENDER;
      req_chan.query_rank   = '0;
      req_chan.unit_index   = '0;
      rsp_chan.ready = 1'b0;
      senders_cfg    = CSR_RESET;
      receivers_cfg  = CSR_RESET;
      steady         = 1'b0;
      mismatch_count = 0;
      quiet_cycles   = 0;
      offer_live     = 1'b0;
      foreach (count_model[r, c]) count_model[r][c] = '0;
      plan_senders[6]   = CSR_BITS'($urandom_range(31));
      plan_receivers[6] = CSR_BITS'($urandom_range(31));
      plan_senders[7]   = CSR_BITS'($urandom_range(31));
      plan_receivers[7] = CSR_BITS'($urandom_range(31));

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // empty table, corner entries, full-scale counts, index past the total
      push_query(ROLE_SENDER, 0, 0);
      push_query(ROLE_RECEIVER, 15, 1);
      push_write(0, 0, 16'hFFFF);
      push_write(15, 15, 16'hFFFF);
      push_write(0, 15, 1);
      push_write(15, 0, 16'hFFFF);
      push_write(7, 8, 16'h5A5A);
      push_query(ROLE_SENDER, 0, 65535);
      push_query(ROLE_SENDER, 0, 65536);
      push_query(ROLE_RECEIVER, 15, 65536);
      push_query(ROLE_SENDER, 15, OFFSET_MAX);
      push_query(ROLE_RECEIVER, 0, 0);
      push_query(ROLE_RECEIVER, 15, 0);
      wait_drained();

      // narrow ranks: writes and queries outside the in-use ranks
      set_ranks(4, 3);
      push_write(5, 1, 77);
      push_write(2, 3, 77);
      push_write(3, 2, 1234);
      push_query(ROLE_SENDER, 4, 0);
      push_query(ROLE_RECEIVER, 3, 0);
      push_query(ROLE_SENDER, 3, 1234);
      push_query(ROLE_RECEIVER, 2, 1234);
      wait_drained();

      // zero acts as one rank, values above the maximum act as the maximum
      set_ranks(0, 31);
      push_write(1, 0, 9);
      push_write(0, 14, 500);
      push_query(ROLE_RECEIVER, 14, 500);
      push_query(ROLE_SENDER, 0, 70000);
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         set_ranks(plan_senders[p], plan_receivers[p]);
         steady = (p == 3);
         queue_phase(215, plan_counts[p]);
         wait_drained();
      end
      steady = 1'b0;

      repeat (DRAIN_WAIT) @(posedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("coupled_index_lookup regression: pass");
      end else begin
         $display("coupled_index_lookup regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
rtl/cil_pkg.sv
rtl/cil_if.sv
rtl/coupled_index_lookup.sv
test/coupled_index_lookup_tb.sv
